// ===== rtl/core/slist_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slist_pkg: shared definitions for the sorted list engine
// Operation and status codes, default capacity and the command / status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package slist_pkg;

   localparam int DATA_W           = 32;
   localparam int CAPACITY_DEFAULT = 16;
   localparam int COUNT_W          = 5;

   // operation codes
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_EDIT   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic       load_op;   // capture the request
      logic       ins_en;    // insert key into the cell row
      logic       del_en;    // remove key from the cell row
      logic       use_new;   // key is new_value instead of value
      logic       rsp_load;  // capture result into output registers
      logic [1:0] status;    // status code for the result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] kind;      // captured operation
      logic       found;     // key is stored
      logic       full;      // no free cell
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/slist_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slist_datapath: compare-and-shift cell row
// Holds the request, the ascending row of value cells, the entry count and
// the output payload registers. Insert or delete shifts the whole row at once.
// ----------------------------------------------------------------------------
module slist_datapath
   import slist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output sts_type                       sts,
   input  wire logic [1:0]               req_kind,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic signed [DATA_W-1:0] req_new_value,
   output logic [1:0]                    rsp_status,
   output logic [COUNT_W-1:0]            rsp_count,
   output logic                          rsp_list_empty,
   output logic signed [DATA_W-1:0]      rsp_smallest
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [1:0]               kind_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] new_value_ff;
   logic signed [DATA_W-1:0] cell_ff [CAPACITY];
   logic signed [DATA_W-1:0] cell_in [CAPACITY];
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W+COUNT_W-1:0] count_ext;
   logic signed [DATA_W-1:0] key;
   logic [CAPACITY-1:0]      valid;
   logic [CAPACITY-1:0]      below;
   logic [CAPACITY-1:0]      equal;
   logic                     full;
   logic signed [DATA_W-1:0] smallest_next;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         kind_ff      <= req_kind;
         value_ff     <= req_value;
         new_value_ff <= req_new_value;
      end
   end

   assign key  = cmd.use_new ? new_value_ff : value_ff;
   assign full = (count_ff == CNT_W'(CAPACITY));

   // per-cell compare and next value
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] ins_val;
      logic signed [DATA_W-1:0] del_val;

      assign valid[i] = (CNT_W'(i) < count_ff);
      assign below[i] = valid[i] && (cell_ff[i] < key);
      assign equal[i] = valid[i] && (cell_ff[i] == key);

      // insert: keep smaller cells, drop key at boundary, shift rest up
      if (i == 0) begin : g_first
         assign ins_val = below[i] ? cell_ff[i] : key;
      end else begin : g_rest
         assign ins_val = below[i] ? cell_ff[i] : (below[i-1] ? key : cell_ff[i-1]);
      end

      // delete: keep smaller cells, pull rest down by one
      if (i == CAPACITY - 1) begin : g_last
         assign del_val = cell_ff[i];
      end else begin : g_inner
         assign del_val = below[i] ? cell_ff[i] : cell_ff[i+1];
      end

      assign cell_in[i] = cmd.ins_en ? ins_val : (cmd.del_en ? del_val : cell_ff[i]);
   end

   // cell row
   always_ff @(posedge clock) begin
      for (int j = 0; j < CAPACITY; j++) begin
         cell_ff[j] <= cell_in[j];
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.del_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result payload, taken from the post-operation state
   assign count_ext     = {{COUNT_W{1'b0}}, count_in};
   assign smallest_next = (count_in == '0) ? '0 : cell_in[0];

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status     <= cmd.status;
         rsp_count      <= count_ext[COUNT_W-1:0];
         rsp_list_empty <= (count_in == '0);
         rsp_smallest   <= smallest_next;
      end
   end

   assign sts.kind  = kind_ff;
   assign sts.found = |equal;
   assign sts.full  = full;

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_ins_not_full : assert property (@(posedge clock) disable iff (reset)
      cmd.ins_en |-> !full)
      else $error("insert issued into full row");

   a_del_found : assert property (@(posedge clock) disable iff (reset)
      cmd.del_en |-> (|equal) && !cmd.ins_en)
      else $error("delete issued without a match");

   a_ins_count : assert property (@(posedge clock) disable iff (reset)
      cmd.ins_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not bump count");

endmodule
`default_nettype wire

// ===== rtl/core/slist_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slist_ctrl: operation sequencer
// Takes a request, runs insert, delete or edit (delete step then insert step
// if the old value is found) and owns the handshake state of both channels.
// ----------------------------------------------------------------------------
module slist_ctrl
   import slist_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_OP   = 2'd1;
   localparam logic [1:0] S_INS  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   // output slot can take a result this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.load_op  = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_OP;
            end
         end
         S_OP: begin
            if (sts.kind == KIND_EDIT && sts.found) begin
               // first half of edit: drop old value
               cmd.del_en = 1'b1;
               state_in   = S_INS;
            end else if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
               case (sts.kind)
                  KIND_INSERT: begin
                     cmd.ins_en = !sts.full;
                     cmd.status = sts.full ? ST_FULL : ST_DONE;
                  end
                  KIND_DELETE: begin
                     cmd.del_en = sts.found;
                     cmd.status = sts.found ? ST_DONE : ST_MISSING;
                  end
                  KIND_EDIT: begin
                     cmd.status = ST_MISSING;
                  end
                  default: begin
                     cmd.status = ST_DONE;
                  end
               endcase
            end
         end
         S_INS: begin
            // second half of edit: place replacement
            cmd.use_new = 1'b1;
            if (slot_free) begin
               cmd.ins_en   = 1'b1;
               cmd.rsp_load = 1'b1;
               cmd.status   = ST_DONE;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   a_load_slot : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> slot_free)
      else $error("result overwrote a pending transfer");

   a_edit_seq : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS |-> $past(state_ff) == S_OP || $past(state_ff) == S_INS)
      else $error("edit insert step entered out of order");

   a_one_op : assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins_en && cmd.del_en))
      else $error("insert and delete in the same cycle");

endmodule
`default_nettype wire

// ===== rtl/core/sorted_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_engine: bounded ascending multiset of signed 32-bit values
// Insert, delete and edit on a row of compare-and-shift cells; one result
// per operation with status, count, empty flag and smallest value.
//
//   Channel  Dir  Ports                                  Transfer
//   req      in   req_kind, req_value, req_new_value     req_valid & req_ready
//   rsp      out  rsp_status, rsp_count, rsp_list_empty, rsp_valid & rsp_ready
//                 rsp_smallest
//
// Insert, delete and unknown codes run a capture step, then a cell-row update;
// edit runs capture, a delete step, then an insert step on the cell row if
// the old value is found. All entries are compared at once, so step counts do
// not depend on CAPACITY. Reset clears only the entry count; no sweep.
// A held result stalls the final step until the output register frees up;
// a new request is taken while a result waits.
// ----------------------------------------------------------------------------
module sorted_list_engine
   import slist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_kind,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic signed [DATA_W-1:0] req_new_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [COUNT_W-1:0]            rsp_count,
   output logic                          rsp_list_empty,
   output logic signed [DATA_W-1:0]      rsp_smallest
);

   cmd_type cmd;
   sts_type sts;

   slist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   slist_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .req_new_value  (req_new_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_list_empty (rsp_list_empty),
      .rsp_smallest   (rsp_smallest)
   );

endmodule
`default_nettype wire
